@@ rtl/core/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg: shared types and constants of the line pixel generator
// Coordinate types, function codes, the setup bundle handed from the
// line setup decoder to the stepper, and the pixel beat format.
// ----------------------------------------------------------------------------
package lpg_pkg;

  // coordinate and color widths
  localparam int CoordW = 12;
  localparam int DiffW  = 13;
  localparam int ColorW = 16;

  // default screen size
  localparam int DefScreenWidth  = 240;
  localparam int DefScreenHeight = 320;

  // function codes of an input beat
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncStep = 1'b1;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic [DiffW-1:0]         mag_t;
  typedef logic [ColorW-1:0]        color_t;

  // decoded line, ready to load into the stepper
  typedef struct packed {
    logic   busy;       // line has at least one pixel to draw
    logic   axis_mode;  // horizontal or vertical run
    logic   steep;      // axes swapped (or vertical run)
    coord_t major_pos;
    coord_t major_end;
    coord_t minor_pos;
    diff_t  err;
    mag_t   dmaj;
    mag_t   dmin;
    logic   dir_neg;    // minor axis steps down
  } setup_t;

  // one output pixel beat
  typedef struct packed {
    coord_t x;
    coord_t y;
    color_t color;
    logic   last;
  } pixel_t;

endpackage

@@ rtl/core/line_pixel_generator.sv @@
// Pixels: a step beat's pixel passes the output buffer registers to out_*.
// Throughput: one beat (load or step) per cycle while in_ready is high, one pixel
//   per cycle while out_ready is high; a two-entry output buffer keeps in_ready
//   registered and high while one pixel waits downstream, low once both are full.
// Reset: synchronous active low; line idle, output buffer empty, in_ready low
//   while in reset and registered high once reset is released.
// ----------------------------------------------------------------------------
// line_pixel_generator: Bresenham line pixel generator
// Load beats set up a line, step beats return its pixels one at a time.
// ----------------------------------------------------------------------------
module line_pixel_generator #(
  parameter int SCREEN_WIDTH  = lpg_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = lpg_pkg::DefScreenHeight
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            in_func,
  input  lpg_pkg::coord_t in_x_start,
  input  lpg_pkg::coord_t in_y_start,
  input  lpg_pkg::coord_t in_x_end,
  input  lpg_pkg::coord_t in_y_end,
  input  lpg_pkg::color_t in_line_color,
  output logic            out_valid,
  input  logic            out_ready,
  output lpg_pkg::coord_t out_pixel_x,
  output lpg_pkg::coord_t out_pixel_y,
  output lpg_pkg::color_t out_pixel_color,
  output logic            out_last_pixel
);

  lpg_pkg::setup_t setup;
  lpg_pkg::pixel_t step_pix, out_pix;
  logic            accept, push;

  assign accept = in_valid && in_ready;

  // endpoint decode
  lpg_setup #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_setup (
    .x_start(in_x_start),
    .y_start(in_y_start),
    .x_end  (in_x_end),
    .y_end  (in_y_end),
    .setup  (setup)
  );

  // line state and stepping
  lpg_stepper u_stepper (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .func      (in_func),
    .line_color(in_line_color),
    .setup     (setup),
    .push      (push),
    .pix       (step_pix)
  );

  // output register stage
  lpg_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_pix (step_pix),
    .ready    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_pix  (out_pix)
  );

  assign out_pixel_x     = out_pix.x;
  assign out_pixel_y     = out_pix.y;
  assign out_pixel_color = out_pix.color;
  assign out_last_pixel  = out_pix.last;

endmodule

@@ rtl/core/lpg_setup.sv @@
// ----------------------------------------------------------------------------
// lpg_setup: line setup decoder
// Turns two endpoints into the stepper start state: axis-aligned runs are
// clipped to the screen, diagonal lines get Bresenham axis swap and ordering.
// ----------------------------------------------------------------------------
module lpg_setup #(
  parameter int SCREEN_WIDTH  = lpg_pkg::DefScreenWidth,
  parameter int SCREEN_HEIGHT = lpg_pkg::DefScreenHeight
) (
  input  lpg_pkg::coord_t x_start,
  input  lpg_pkg::coord_t y_start,
  input  lpg_pkg::coord_t x_end,
  input  lpg_pkg::coord_t y_end,
  output lpg_pkg::setup_t setup
);

  localparam logic signed [13:0] WidthLim  = 14'(SCREEN_WIDTH);
  localparam logic signed [13:0] HeightLim = 14'(SCREEN_HEIGHT);

  lpg_pkg::diff_t  dx, dy, adx, ady;
  logic            vert, horz;
  lpg_pkg::coord_t run_fixed, run_lo;
  lpg_pkg::diff_t  run_len;
  logic signed [13:0] fixed_lim, run_lim, run_sum, run_end;
  logic            in_screen, run_ok;
  logic            steep, swap;
  lpg_pkg::coord_t ma0, ma1, mi0, mi1;
  lpg_pkg::diff_t  dma, dmi;
  lpg_pkg::mag_t   dmaj;

  // endpoint differences and magnitudes
  always_comb begin
    dx  = lpg_pkg::DiffW'(x_end) - lpg_pkg::DiffW'(x_start);
    dy  = lpg_pkg::DiffW'(y_end) - lpg_pkg::DiffW'(y_start);
    adx = dx[lpg_pkg::DiffW-1] ? -dx : dx;
    ady = dy[lpg_pkg::DiffW-1] ? -dy : dy;
    vert = (x_start == x_end);
    horz = (y_start == y_end);
  end

  // axis-aligned run: start at lower coordinate, clip at the screen edge
  always_comb begin
    if (vert) begin
      run_fixed = x_start;
      run_lo    = (dy > 13'sd0) ? y_start : y_end;
      run_len   = ady;
      fixed_lim = WidthLim;
      run_lim   = HeightLim;
    end else begin
      run_fixed = y_start;
      run_lo    = (dx > 13'sd0) ? x_start : x_end;
      run_len   = adx;
      fixed_lim = HeightLim;
      run_lim   = WidthLim;
    end
    in_screen = !run_fixed[lpg_pkg::CoordW-1] && (14'(run_fixed) < fixed_lim) &&
                !run_lo[lpg_pkg::CoordW-1] && (14'(run_lo) < run_lim);
    run_sum = 14'(run_lo) + 14'(run_len);
    run_end = (run_sum > run_lim) ? run_lim - 14'sd1 : run_sum - 14'sd1;
    run_ok  = in_screen && (run_len != '0);
  end

  // diagonal line: swap axes when steep, order along the major axis
  always_comb begin
    steep = ady > adx;
    ma0   = steep ? y_start : x_start;
    ma1   = steep ? y_end   : x_end;
    mi0   = steep ? x_start : y_start;
    mi1   = steep ? x_end   : y_end;
    dma   = steep ? dy : dx;
    dmi   = steep ? dx : dy;
    swap  = dma[lpg_pkg::DiffW-1];
    dmaj  = $unsigned(steep ? ady : adx);
  end

  // pick run or diagonal start state
  always_comb begin
    if (vert || horz) begin
      setup.busy      = run_ok;
      setup.axis_mode = 1'b1;
      setup.steep     = vert;
      setup.major_pos = run_lo;
      setup.major_end = run_end[lpg_pkg::CoordW-1:0];
      setup.minor_pos = run_fixed;
    end else begin
      setup.busy      = 1'b1;
      setup.axis_mode = 1'b0;
      setup.steep     = steep;
      setup.major_pos = swap ? ma1 : ma0;
      setup.major_end = swap ? ma0 : ma1;
      setup.minor_pos = swap ? mi1 : mi0;
    end
    setup.dmaj    = dmaj;
    setup.dmin    = $unsigned(steep ? adx : ady);
    setup.err     = $signed({1'b0, dmaj[lpg_pkg::DiffW-1:1]});
    setup.dir_neg = swap ? !(dmi < 13'sd0) : !(dmi > 13'sd0);
  end

endmodule

@@ rtl/core/lpg_stepper.sv @@
// ----------------------------------------------------------------------------
// lpg_stepper: line state and per-pixel step
// Holds the current line, emits one pixel per step beat while the line is busy
// and advances the major axis, the Bresenham error term and the minor axis.
// ----------------------------------------------------------------------------
module lpg_stepper (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             func,
  input  lpg_pkg::color_t  line_color,
  input  lpg_pkg::setup_t  setup,
  output logic             push,
  output lpg_pkg::pixel_t  pix
);

  logic            busy_r, busy_nxt;
  logic            axis_r, steep_r, dir_neg_r;
  lpg_pkg::coord_t major_r, major_end_r, minor_r;
  lpg_pkg::diff_t  err_r;
  lpg_pkg::mag_t   dmaj_r, dmin_r;
  lpg_pkg::color_t color_r;

  logic               last;
  logic signed [13:0] err_sub, err_add;
  lpg_pkg::coord_t    major_nxt, minor_nxt;
  lpg_pkg::diff_t     err_nxt;
  logic               step;

  // pixel of the current position
  always_comb begin
    step      = accept && (func == lpg_pkg::FuncStep) && busy_r;
    push      = step;
    last      = major_r >= major_end_r;
    pix.x     = steep_r ? minor_r : major_r;
    pix.y     = steep_r ? major_r : minor_r;
    pix.color = color_r;
    pix.last  = last;
  end

  // advance along the line
  always_comb begin
    err_sub   = 14'(err_r) - $signed({1'b0, dmin_r});
    err_add   = err_sub + $signed({1'b0, dmaj_r});
    err_nxt   = err_r;
    minor_nxt = minor_r;
    if (!axis_r) begin
      if (err_sub[13]) begin
        err_nxt   = err_add[lpg_pkg::DiffW-1:0];
        minor_nxt = dir_neg_r ? minor_r - 12'sd1 : minor_r + 12'sd1;
      end else begin
        err_nxt = err_sub[lpg_pkg::DiffW-1:0];
      end
    end
    major_nxt = last ? major_r : major_r + 12'sd1;
    busy_nxt  = busy_r && !last;
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept && (func == lpg_pkg::FuncLoad)) begin
      busy_r <= setup.busy;
    end else if (step) begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (func == lpg_pkg::FuncLoad)) begin
      color_r     <= line_color;
      axis_r      <= setup.axis_mode;
      steep_r     <= setup.steep;
      major_r     <= setup.major_pos;
      major_end_r <= setup.major_end;
      minor_r     <= setup.minor_pos;
      err_r       <= setup.err;
      dmaj_r      <= setup.dmaj;
      dmin_r      <= setup.dmin;
      dir_neg_r   <= setup.dir_neg;
    end else if (step) begin
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ rtl/core/lpg_out_buf.sv @@
// ----------------------------------------------------------------------------
// lpg_out_buf: two-entry pixel output buffer
// Registers pixel beats and decouples input ready from output ready, so a
// new beat is taken while one pixel still waits downstream.
// ----------------------------------------------------------------------------
module lpg_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lpg_pkg::pixel_t push_pix,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_ready,
  output lpg_pkg::pixel_t out_pix
);

  lpg_pkg::pixel_t slot0_r, slot1_r;
  logic            valid0_r, valid1_r, ready_r;
  logic            valid0_nxt, valid1_nxt;
  logic            pop;

  // occupancy update
  always_comb begin
    pop        = valid0_r && out_ready;
    valid0_nxt = valid0_r;
    valid1_nxt = valid1_r;
    if (pop) begin
      if (valid1_r) begin
        valid1_nxt = 1'b0;
      end else begin
        valid0_nxt = push;
      end
    end else if (push) begin
      if (valid0_r) begin
        valid1_nxt = 1'b1;
      end else begin
        valid0_nxt = 1'b1;
      end
    end
  end

  // control state, ready is registered off the buffer fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
      valid1_r <= 1'b0;
      ready_r  <= 1'b0;
    end else begin
      valid0_r <= valid0_nxt;
      valid1_r <= valid1_nxt;
      ready_r  <= !valid1_nxt;
    end
  end

  // pixel slots
  always_ff @(posedge clk) begin
    if (pop) begin
      if (valid1_r) begin
        slot0_r <= slot1_r;
      end else if (push) begin
        slot0_r <= push_pix;
      end
    end else if (push) begin
      if (valid0_r) begin
        slot1_r <= push_pix;
      end else begin
        slot0_r <= push_pix;
      end
    end
  end

  assign ready     = ready_r;
  assign out_valid = valid0_r;
  assign out_pix   = slot0_r;

endmodule

@@ rtl/core/lpg_checker.sv @@
// ----------------------------------------------------------------------------
// lpg_checker: port-level checks of the line pixel generator
// Watches the handshakes on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module lpg_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            in_func,
  input logic            out_valid,
  input logic            out_ready,
  input lpg_pkg::coord_t out_pixel_x,
  input lpg_pkg::coord_t out_pixel_y,
  input lpg_pkg::color_t out_pixel_color,
  input logic            out_last_pixel
);

  // a pending pixel beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) &&
      $stable(out_pixel_y) && $stable(out_pixel_color) && $stable(out_last_pixel))
    else $error("pixel beat dropped or changed while stalled");

  // a new pixel only follows an accepted step beat
  a_pixel_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_func == lpg_pkg::FuncStep)))
    else $error("pixel beat without a step beat");

  // with nothing buffered the input side is open
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid |-> in_ready)
    else $error("input stalled with an empty output buffer");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel beat present after reset");

endmodule

bind line_pixel_generator lpg_checker u_lpg_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_pixel_x    (out_pixel_x),
  .out_pixel_y    (out_pixel_y),
  .out_pixel_color(out_pixel_color),
  .out_last_pixel (out_last_pixel)
);
